>>> rtl/display_strip_scheduler_macros.svh
// ----------------------------------------------------------------------------
// display_strip_scheduler_macros
// Assertion macros shared by the strip scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_STRIP_SCHEDULER_MACROS_SVH
`define DISPLAY_STRIP_SCHEDULER_MACROS_SVH

// same-cycle implication, checked out of reset
`define DSS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Types, codes and helpers shared by the strip scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_EXT  = (IDX_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(QUEUE_DEPTH);

  localparam logic [14:0] PANEL_RESET = 15'd256;

  // action codes
  localparam logic [2:0] ACT_SCHEDULE = 3'd0;
  localparam logic [2:0] ACT_FETCH    = 3'd1;
  localparam logic [2:0] ACT_COMPLETE = 3'd2;
  localparam logic [2:0] ACT_ABORT    = 3'd3;
  localparam logic [2:0] ACT_SET_REV  = 3'd4;
  localparam logic [2:0] ACT_READ_CNT = 3'd5;

  // counter select codes; selects below SEL_QUEUED name a statistics counter
  localparam logic [2:0] SEL_QUEUED = 3'd4;

  // statistics counter slots
  localparam logic [1:0] STAT_ACCEPTED  = 2'd0;
  localparam logic [1:0] STAT_COMPLETED = 2'd1;
  localparam logic [1:0] STAT_REJECTED  = 2'd2;
  localparam logic [1:0] STAT_STALE     = 2'd3;

  // configuration register indexes
  localparam logic CFG_PANEL_WIDTH  = 1'b0;
  localparam logic CFG_PANEL_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCHED,
    ST_FETCH,
    ST_RETIRE,
    ST_DROP_WAIT,
    ST_DROP_CHK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] stride;
    logic [31:0] revision;
    logic [31:0] address;
  } strip_entry_t;

  // sequence numbers skip zero on wrap
  function automatic logic [31:0] next_nonzero(input logic [31:0] s);
    logic [31:0] n;
    n = s + 32'd1;
    return (n == 32'd0) ? 32'd1 : n;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dss_strip_mem.sv
// ----------------------------------------------------------------------------
// dss_strip_mem
// Strip entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_strip_mem
  import dss_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire strip_entry_t wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output strip_entry_t      rd_data
);

  strip_entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/dss_check.sv
// ----------------------------------------------------------------------------
// dss_check
// Two-stage strip validation: bounds, alignment, stride and buffer size.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_check
  import dss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [15:0] left_x,
  input  wire logic signed [15:0] top_y,
  input  wire logic signed [15:0] right_x,
  input  wire logic signed [15:0] bottom_y,
  input  wire logic signed [15:0] row_stride,
  input  wire logic [31:0]        revision,
  input  wire logic [31:0]        cur_revision,
  input  wire logic [31:0]        pixel_count,
  input  wire logic [14:0]        panel_width,
  input  wire logic [14:0]        panel_height,
  output logic                    strip_ok
);

  logic signed [16:0] w, h, hm1, stride_ext;
  logic signed [32:0] prod;
  logic               basic_ok_nxt, basic_ok_r;
  logic signed [34:0] need_nxt, need_r;

  always_comb begin
    w          = $signed({right_x[15], right_x}) - $signed({left_x[15], left_x});
    h          = $signed({bottom_y[15], bottom_y}) - $signed({top_y[15], top_y});
    hm1        = h - 17'sd1;
    stride_ext = $signed({row_stride[15], row_stride});
    prod       = hm1 * stride_ext;
    need_nxt   = $signed({{2{prod[32]}}, prod}) + $signed({{18{w[16]}}, w});
    basic_ok_nxt = (revision == cur_revision) &&
                   (w > 17'sd0) && (h > 17'sd0) &&
                   !left_x[15] && !top_y[15] &&
                   ($signed({right_x[15], right_x}) <= $signed({2'b00, panel_width})) &&
                   ($signed({bottom_y[15], bottom_y}) <= $signed({2'b00, panel_height})) &&
                   ((left_x[0] | top_y[0] | w[0] | h[0]) == 1'b0) &&
                   (stride_ext >= w);
  end

  // stage register after the multiply
  always_ff @(posedge clk) begin
    basic_ok_r <= basic_ok_nxt;
    need_r     <= need_nxt;
  end

  assign strip_ok = basic_ok_r && ($signed({3'b000, pixel_count}) >= need_r);

endmodule

`default_nettype wire

>>> rtl/display_strip_scheduler.sv
// ----------------------------------------------------------------------------
// display_strip_scheduler
// Ring queue of display strips with sequence numbers, one strip in flight.
// ----------------------------------------------------------------------------
// One transaction at a time: a command is taken when start is high and busy
// is low, and exactly one result comes back on out_strobe, held for a single
// cycle; the receiver cannot stall it, so it must take every strobe. Schedule
// runs through CHECK and SCHED (the 17x16 size multiply has its own stage),
// fetch through FETCH, read counter and unknown commands through RESP, set
// revision through DROP_CHK, complete/abort through RETIRE, then DROP_WAIT
// and DROP_CHK on success; each stale head dropped afterwards repeats both,
// as the store reads the head through a register. The next command may be
// taken in the cycle the strobe is up. The store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "display_strip_scheduler_macros.svh"

module display_strip_scheduler
  import dss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [14:0]        cfg_data,
  // command
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_action,
  input  wire logic signed [15:0] in_left_x,
  input  wire logic signed [15:0] in_top_y,
  input  wire logic signed [15:0] in_right_x,
  input  wire logic signed [15:0] in_bottom_y,
  input  wire logic signed [15:0] in_row_stride,
  input  wire logic [31:0]        in_revision_in,
  input  wire logic [31:0]        in_pixel_base,
  input  wire logic [31:0]        in_pixel_count,
  input  wire logic [31:0]        in_sequence_number,
  input  wire logic [2:0]         in_counter_select,
  // result
  output logic                    out_strobe,
  output logic                    out_ok,
  output logic [31:0]             out_sequence_out,
  output logic signed [15:0]      out_left,
  output logic signed [15:0]      out_top,
  output logic signed [15:0]      out_right,
  output logic signed [15:0]      out_bottom,
  output logic signed [15:0]      out_stride,
  output logic [31:0]             out_revision,
  output logic [31:0]             out_pixel_base,
  output logic [31:0]             out_counter_value
);

  // control state
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [31:0]       next_seq_r, next_seq_nxt;
  logic [31:0]       front_r, front_nxt;
  logic [31:0]       inflight_r, inflight_nxt;
  logic [31:0]       cur_rev_r, cur_rev_nxt;
  logic [31:0]       stat_r [4];
  logic [31:0]       stat_nxt [4];
  logic [14:0]       panel_w_r, panel_h_r;

  // latched transaction payload
  logic [2:0]         act_r;
  logic signed [15:0] x0_r, y0_r, x1_r, y1_r, stride_r;
  logic [31:0]        rev_r, base_r, pcount_r, seq_r;
  logic [2:0]         sel_r;

  // result registers
  logic               strobe_r, strobe_nxt;
  logic               ok_r, ok_nxt;
  logic [31:0]        seq_out_r, seq_out_nxt;
  strip_entry_t       strip_out_r, strip_out_nxt;
  logic [31:0]        cnt_out_r, cnt_out_nxt;

  // store ports
  logic               wr_en;
  logic [IDX_W-1:0]   tail;
  logic [IDX_W:0]     tail_sum;
  strip_entry_t       wr_data, head_entry;

  logic               accept, strip_ok, full, retire_hit;
  logic [IDX_W-1:0]   head_inc;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // tail is head + count modulo the queue depth
  assign tail_sum = {1'b0, head_r} + (IDX_W + 1)'(count_r);
  assign tail     = (tail_sum >= DEPTH_EXT) ? IDX_W'(tail_sum - DEPTH_EXT)
                                            : tail_sum[IDX_W-1:0];
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign full     = (count_r == DEPTH_CNT);

  assign retire_hit = (count_r != '0) && (seq_r == front_r) && (seq_r == inflight_r);

  assign wr_data = '{left: x0_r, top: y0_r, right: x1_r, bottom: y1_r,
                     stride: stride_r, revision: rev_r, address: base_r};

  // head is read every cycle; a write is never followed by a head read
  // in the same cycle because busy holds off the next transaction
  dss_strip_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (wr_data),
    .rd_addr (head_r),
    .rd_data (head_entry)
  );

  dss_check u_check (
    .clk          (clk),
    .left_x       (x0_r),
    .top_y        (y0_r),
    .right_x      (x1_r),
    .bottom_y     (y1_r),
    .row_stride   (stride_r),
    .revision     (rev_r),
    .cur_revision (cur_rev_r),
    .pixel_count  (pcount_r),
    .panel_width  (panel_w_r),
    .panel_height (panel_h_r),
    .strip_ok     (strip_ok)
  );

  // next state, queue update and result
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    next_seq_nxt = next_seq_r;
    front_nxt    = front_r;
    inflight_nxt = inflight_r;
    cur_rev_nxt  = cur_rev_r;
    stat_nxt     = stat_r;
    wr_en        = 1'b0;
    strobe_nxt   = 1'b0;
    ok_nxt       = 1'b0;
    seq_out_nxt  = '0;
    strip_out_nxt = '0;
    cnt_out_nxt  = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_SCHEDULE: state_nxt = ST_CHECK;
            ACT_FETCH:    state_nxt = ST_FETCH;
            ACT_COMPLETE: state_nxt = ST_RETIRE;
            ACT_ABORT:    state_nxt = ST_RETIRE;
            ACT_SET_REV: begin
              // head read in this cycle is still valid for the drop check
              cur_rev_nxt = in_revision_in;
              state_nxt   = ST_DROP_CHK;
            end
            default:      state_nxt = ST_RESP;
          endcase
        end
      end

      ST_CHECK: state_nxt = ST_SCHED;

      ST_SCHED: begin
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
        if (strip_ok && !full) begin
          wr_en        = 1'b1;
          next_seq_nxt = next_nonzero(next_seq_r);
          if (count_r == '0) begin
            front_nxt = next_seq_r;
          end
          count_nxt = count_r + 1'b1;
          stat_nxt[STAT_ACCEPTED] = stat_r[STAT_ACCEPTED] + 32'd1;
          ok_nxt      = 1'b1;
          seq_out_nxt = next_seq_r;
        end else begin
          stat_nxt[STAT_REJECTED] = stat_r[STAT_REJECTED] + 32'd1;
          if (rev_r != cur_rev_r) begin
            stat_nxt[STAT_STALE] = stat_r[STAT_STALE] + 32'd1;
          end
        end
      end

      ST_FETCH: begin
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
        if ((count_r != '0) && (inflight_r == 32'd0)) begin
          inflight_nxt  = front_r;
          ok_nxt        = 1'b1;
          seq_out_nxt   = front_r;
          strip_out_nxt = head_entry;
        end
      end

      ST_RETIRE: begin
        if (retire_hit) begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
          front_nxt = (count_r == CNT_W'(1)) ? 32'd0 : next_nonzero(front_r);
          if (act_r == ACT_COMPLETE) begin
            stat_nxt[STAT_COMPLETED] = stat_r[STAT_COMPLETED] + 32'd1;
          end else begin
            stat_nxt[STAT_REJECTED] = stat_r[STAT_REJECTED] + 32'd1;
          end
          inflight_nxt = 32'd0;
          state_nxt    = ST_DROP_WAIT;
        end else begin
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end

      // head moved: wait for the store's read register to present the new head
      ST_DROP_WAIT: state_nxt = ST_DROP_CHK;

      ST_DROP_CHK: begin
        if ((count_r != '0) && (inflight_r == 32'd0) &&
            (head_entry.revision != cur_rev_r)) begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
          front_nxt = (count_r == CNT_W'(1)) ? 32'd0 : next_nonzero(front_r);
          stat_nxt[STAT_REJECTED] = stat_r[STAT_REJECTED] + 32'd1;
          stat_nxt[STAT_STALE]    = stat_r[STAT_STALE] + 32'd1;
          state_nxt = ST_DROP_WAIT;
        end else begin
          strobe_nxt = 1'b1;
          ok_nxt     = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end

      ST_RESP: begin
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
        if (act_r == ACT_READ_CNT) begin
          if (sel_r == SEL_QUEUED) begin
            ok_nxt      = 1'b1;
            cnt_out_nxt = 32'(count_r);
          end else if (sel_r < SEL_QUEUED) begin
            ok_nxt      = 1'b1;
            cnt_out_nxt = stat_r[sel_r[1:0]];
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      head_r     <= '0;
      count_r    <= '0;
      next_seq_r <= 32'd1;
      front_r    <= '0;
      inflight_r <= '0;
      cur_rev_r  <= '0;
      stat_r     <= '{default: '0};
      panel_w_r  <= PANEL_RESET;
      panel_h_r  <= PANEL_RESET;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      next_seq_r <= next_seq_nxt;
      front_r    <= front_nxt;
      inflight_r <= inflight_nxt;
      cur_rev_r  <= cur_rev_nxt;
      stat_r     <= stat_nxt;
      strobe_r   <= strobe_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_PANEL_WIDTH) begin
          panel_w_r <= cfg_data;
        end else begin
          panel_h_r <= cfg_data;
        end
      end
    end
  end

  // transaction payload, captured on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_action;
      x0_r     <= in_left_x;
      y0_r     <= in_top_y;
      x1_r     <= in_right_x;
      y1_r     <= in_bottom_y;
      stride_r <= in_row_stride;
      rev_r    <= in_revision_in;
      base_r   <= in_pixel_base;
      pcount_r <= in_pixel_count;
      seq_r    <= in_sequence_number;
      sel_r    <= in_counter_select;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    ok_r        <= ok_nxt;
    seq_out_r   <= seq_out_nxt;
    strip_out_r <= strip_out_nxt;
    cnt_out_r   <= cnt_out_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_ok            = ok_r;
  assign out_sequence_out  = seq_out_r;
  assign out_left          = $signed(strip_out_r.left);
  assign out_top           = $signed(strip_out_r.top);
  assign out_right         = $signed(strip_out_r.right);
  assign out_bottom        = $signed(strip_out_r.bottom);
  assign out_stride        = $signed(strip_out_r.stride);
  assign out_revision      = strip_out_r.revision;
  assign out_pixel_base    = strip_out_r.address;
  assign out_counter_value = cnt_out_r;

  // a strip in flight is always the queued head
  `DSS_ASSERT_IMPLY(a_inflight_queued, inflight_r != 32'd0, count_r != '0, "in flight with empty queue")
  // front sequence is zero exactly when the queue is empty
  `DSS_ASSERT_IMPLY(a_front_empty, count_r == '0, front_r == 32'd0, "front sequence set on empty queue")
  // one result per transaction, one cycle wide
  `DSS_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe held over two cycles")
  // an accepted transaction always occupies the block
  `DSS_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transaction left block idle")

endmodule

`default_nettype wire

>>> tb/tb_display_strip_scheduler.sv
// ----------------------------------------------------------------------------
// tb_display_strip_scheduler
// Self-checking bench for the strip scheduler. A scoreboard keeps its own
// copy of the ring queue, the sequence numbers, the revision and the
// statistics, predicts the single result of every accepted transaction and
// checks the strobed results in order. A short directed run is followed by
// randomised traffic over several panel settings and sender idle rates.
// ----------------------------------------------------------------------------
module tb_display_strip_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import dss_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 650;
  localparam int SEGMENTS      = 6;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES  = 400000;

  // sender idle chances, in percent
  localparam int IDLE_LIGHT = 11;
  localparam int IDLE_HEAVY = 61;

  // codes the block does not define
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic [2:0] SEL_SPARE_LO = 3'd5;
  localparam logic [2:0] SEL_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]         action;
    logic signed [15:0] left_x;
    logic signed [15:0] top_y;
    logic signed [15:0] right_x;
    logic signed [15:0] bottom_y;
    logic signed [15:0] row_stride;
    logic [31:0]        revision;
    logic [31:0]        pixel_base;
    logic [31:0]        pixel_count;
    logic [31:0]        sequence_number;
    logic [2:0]         counter_select;
  } strip_cmd_t;

  typedef struct {
    logic               ok;
    logic [31:0]        seq_no;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic signed [15:0] stride;
    logic [31:0]        revision;
    logic [31:0]        pixel_base;
    logic [31:0]        counter_value;
  } strip_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the queue state and holds the expected results
  // --------------------------------------------------------------------------
  class strip_scoreboard;
    logic [14:0]      width_limit;
    logic [14:0]      height_limit;
    strip_entry_t     ring [QUEUE_DEPTH];
    logic [IDX_W-1:0] head;
    logic [CNT_W-1:0] used;
    logic [31:0]      seq_next;
    logic [31:0]      seq_front;
    logic [31:0]      seq_flight;
    logic [31:0]      rev_now;
    logic [31:0]      stats [4];
    strip_result_t    pending_results [$];
    int               errors;

    function new();
      width_limit  = PANEL_RESET;
      height_limit = PANEL_RESET;
      foreach (ring[i]) ring[i] = '0;
      foreach (stats[i]) stats[i] = '0;
      head       = '0;
      used       = '0;
      seq_next   = 32'd1;
      seq_front  = '0;
      seq_flight = '0;
      rev_now    = '0;
      errors     = 0;
    endfunction

    function void set_panel(logic [14:0] w, logic [14:0] h);
      width_limit  = w;
      height_limit = h;
    endfunction

    // zero is never handed out as a sequence number
    function logic [31:0] next_seq_of(logic [31:0] s);
      logic [31:0] n;
      n = s + 32'd1;
      return (n == '0) ? 32'd1 : n;
    endfunction

    function void pop_head();
      head = IDX_W'((int'(head) + 1) % QUEUE_DEPTH);
      used = used - 1'b1;
      seq_front = (used == '0) ? '0 : next_seq_of(seq_front);
    endfunction

    function void drop_stale();
      while (used != '0 && seq_flight == '0 && ring[head].revision != rev_now) begin
        pop_head();
        stats[STAT_REJECTED]++;
        stats[STAT_STALE]++;
      end
    endfunction

    function void note_command(strip_cmd_t c);
      strip_result_t    r;
      int               x0, y0, x1, y1, w, h, stride;
      longint           need;
      bit               fits;
      logic [IDX_W-1:0] tail;
      r = '{default: '0};
      case (c.action)
        ACT_SCHEDULE: begin
          x0 = c.left_x;
          y0 = c.top_y;
          x1 = c.right_x;
          y1 = c.bottom_y;
          stride = c.row_stride;
          w = x1 - x0;
          h = y1 - y0;
          need = longint'(h - 1) * longint'(stride) + longint'(w);
          fits = (c.revision == rev_now) && w > 0 && h > 0 && x0 >= 0 && y0 >= 0 &&
                 x1 <= int'(width_limit) && y1 <= int'(height_limit) &&
                 ((x0 | y0 | w | h) & 1) == 0 && stride >= w &&
                 longint'(c.pixel_count) >= need;
          if (!fits || used >= DEPTH_CNT) begin
            stats[STAT_REJECTED]++;
            if (c.revision != rev_now) stats[STAT_STALE]++;
          end else begin
            tail = IDX_W'((int'(head) + int'(used)) % QUEUE_DEPTH);
            ring[tail] = '{left: c.left_x, top: c.top_y, right: c.right_x,
                           bottom: c.bottom_y, stride: c.row_stride,
                           revision: c.revision, address: c.pixel_base};
            if (used == '0) seq_front = seq_next;
            r.ok = 1'b1;
            r.seq_no = seq_next;
            seq_next = next_seq_of(seq_next);
            used = used + 1'b1;
            stats[STAT_ACCEPTED]++;
          end
        end
        ACT_FETCH: begin
          if (used != '0 && seq_flight == '0) begin
            seq_flight   = seq_front;
            r.ok         = 1'b1;
            r.seq_no     = seq_front;
            r.left       = ring[head].left;
            r.top        = ring[head].top;
            r.right      = ring[head].right;
            r.bottom     = ring[head].bottom;
            r.stride     = ring[head].stride;
            r.revision   = ring[head].revision;
            r.pixel_base = ring[head].address;
          end
        end
        ACT_COMPLETE, ACT_ABORT: begin
          if (used != '0 && c.sequence_number == seq_front &&
              c.sequence_number == seq_flight) begin
            pop_head();
            if (c.action == ACT_COMPLETE) stats[STAT_COMPLETED]++;
            else stats[STAT_REJECTED]++;
            seq_flight = '0;
            drop_stale();
            r.ok = 1'b1;
          end
        end
        ACT_SET_REV: begin
          rev_now = c.revision;
          drop_stale();
          r.ok = 1'b1;
        end
        ACT_READ_CNT: begin
          if (c.counter_select < SEL_QUEUED) begin
            r.ok = 1'b1;
            r.counter_value = stats[c.counter_select[1:0]];
          end else if (c.counter_select == SEL_QUEUED) begin
            r.ok = 1'b1;
            r.counter_value = 32'(used);
          end
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(strip_result_t got);
      strip_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none, actual ok %0d seq %h",
                 $time, got.ok, got.seq_no);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("ok", want.ok, got.ok);
      compare_field("sequence_out", want.seq_no, got.seq_no);
      compare_field("out_left", want.left, got.left);
      compare_field("out_top", want.top, got.top);
      compare_field("out_right", want.right, got.right);
      compare_field("out_bottom", want.bottom, got.bottom);
      compare_field("out_stride", want.stride, got.stride);
      compare_field("out_revision", want.revision, got.revision);
      compare_field("out_pixel_base", want.pixel_base, got.pixel_base);
      compare_field("counter_value", want.counter_value, got.counter_value);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its signals
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic [14:0]        cfg_data;
  logic               start;
  logic               busy;
  logic [2:0]         in_action;
  logic signed [15:0] in_left_x;
  logic signed [15:0] in_top_y;
  logic signed [15:0] in_right_x;
  logic signed [15:0] in_bottom_y;
  logic signed [15:0] in_row_stride;
  logic [31:0]        in_revision_in;
  logic [31:0]        in_pixel_base;
  logic [31:0]        in_pixel_count;
  logic [31:0]        in_sequence_number;
  logic [2:0]         in_counter_select;
  logic               out_strobe;
  logic               out_ok;
  logic [31:0]        out_sequence_out;
  logic signed [15:0] out_left;
  logic signed [15:0] out_top;
  logic signed [15:0] out_right;
  logic signed [15:0] out_bottom;
  logic signed [15:0] out_stride;
  logic [31:0]        out_revision;
  logic [31:0]        out_pixel_base;
  logic [31:0]        out_counter_value;

  strip_scoreboard sb;
  int              cycle_count = 0;
  int              fill_burst  = 0;   // schedules left in a queue-filling run

  display_strip_scheduler dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_left_x          (in_left_x),
    .in_top_y           (in_top_y),
    .in_right_x         (in_right_x),
    .in_bottom_y        (in_bottom_y),
    .in_row_stride      (in_row_stride),
    .in_revision_in     (in_revision_in),
    .in_pixel_base      (in_pixel_base),
    .in_pixel_count     (in_pixel_count),
    .in_sequence_number (in_sequence_number),
    .in_counter_select  (in_counter_select),
    .out_strobe         (out_strobe),
    .out_ok             (out_ok),
    .out_sequence_out   (out_sequence_out),
    .out_left           (out_left),
    .out_top            (out_top),
    .out_right          (out_right),
    .out_bottom         (out_bottom),
    .out_stride         (out_stride),
    .out_revision       (out_revision),
    .out_pixel_base     (out_pixel_base),
    .out_counter_value  (out_counter_value)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result monitor. The strobe lasts one cycle and cannot be held off, so
  // every strobe sampled at an edge is one result transaction.
  always @(posedge clk) begin : result_monitor
    strip_result_t seen;
    if (rst_n && out_strobe) begin
      seen.ok            = out_ok;
      seen.seq_no        = out_sequence_out;
      seen.left          = out_left;
      seen.top           = out_top;
      seen.right         = out_right;
      seen.bottom        = out_bottom;
      seen.stride        = out_stride;
      seen.revision      = out_revision;
      seen.pixel_base    = out_pixel_base;
      seen.counter_value = out_counter_value;
      sb.check_result(seen);
    end
  end

  // --------------------------------------------------------------------------
  // Command builders
  // --------------------------------------------------------------------------

  // every field random; the action decides which ones matter
  function automatic strip_cmd_t noise_cmd(logic [2:0] act);
    strip_cmd_t c;
    c.action          = act;
    c.left_x          = 16'($urandom);
    c.top_y           = 16'($urandom);
    c.right_x         = 16'($urandom);
    c.bottom_y        = 16'($urandom);
    c.row_stride      = 16'($urandom);
    c.revision        = $urandom;
    c.pixel_base      = $urandom;
    c.pixel_count     = $urandom;
    c.sequence_number = $urandom;
    c.counter_select  = 3'($urandom);
    return c;
  endfunction

  function automatic strip_cmd_t strip_at(int x0, int y0, int x1, int y1, int stride,
                                          logic [31:0] rev, logic [31:0] count);
    strip_cmd_t c;
    c = noise_cmd(ACT_SCHEDULE);
    c.left_x      = 16'(x0);
    c.top_y       = 16'(y0);
    c.right_x     = 16'(x1);
    c.bottom_y    = 16'(y1);
    c.row_stride  = 16'(stride);
    c.revision    = rev;
    c.pixel_count = count;
    return c;
  endfunction

  // even extent within a limit (two when the limit is below two), mostly small, now and then the whole panel
  function automatic int pick_span(int limit);
    int reach;
    if (limit < 2) return 2;
    reach = limit / 2;
    if ($urandom_range(0, 15) == 0) return 2 * reach;
    if (reach > 8 && $urandom_range(0, 3) != 0) reach = 8;
    return 2 * int'($urandom_range(1, reach));
  endfunction

  // A strip that fits the current panel and revision; with spoil set, one
  // of the checks is made to fail.
  function automatic strip_cmd_t make_strip(bit spoil);
    strip_cmd_t c;
    int         pw, ph, w, h, x0, y0, stride;
    longint     need;
    pw = sb.width_limit;
    ph = sb.height_limit;
    w  = pick_span(pw);
    h  = pick_span(ph);
    x0 = (pw >= w) ? 2 * int'($urandom_range(0, (pw - w) / 2)) : 0;
    y0 = (ph >= h) ? 2 * int'($urandom_range(0, (ph - h) / 2)) : 0;
    stride = w + (($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 32767 - w))
                                              : int'($urandom_range(0, 3)));
    need = longint'(h - 1) * longint'(stride) + longint'(w);
    c = strip_at(x0, y0, x0 + w, y0 + h, stride, sb.rev_now, 32'(need));
    if ($urandom_range(0, 3) == 0) c.pixel_count = 32'(need + $urandom_range(0, 5000));
    if (spoil) begin
      case ($urandom_range(0, 7))
        0: c.revision = c.revision ^ (32'd1 << $urandom_range(0, 31));
        1: c.left_x = c.left_x + 16'sd1;                       // odd origin and width
        2: c.top_y = c.top_y + 16'sd1;
        3: begin
          if ($urandom_range(0, 1)) c.left_x = 16'(-2 * int'($urandom_range(1, 16384)));
          else c.top_y = 16'(-2 * int'($urandom_range(1, 16384)));
        end
        4: c.right_x = 16'(pw + 1 + int'($urandom_range(0, 2)));  // past the panel
        5: c.row_stride = 16'(w - 1 - int'($urandom_range(0, 3)));
        6: c.bottom_y = ($urandom_range(0, 1)) ? c.top_y : c.top_y - 16'sd2;
        default: c.pixel_count = 32'(need - 1 - $urandom_range(0, 1));
      endcase
    end
    return c;
  endfunction

  // Mostly well-formed traffic: valid strips, fetches, retires of the strip
  // in flight, revision changes that leave stale heads behind.
  function automatic strip_cmd_t random_command();
    strip_cmd_t c;
    int         pick;
    if (fill_burst > 0) begin
      fill_burst--;
      return make_strip(1'b0);
    end
    if ($urandom_range(0, 99) < 3) fill_burst = 18;   // overruns the ring
    pick = $urandom_range(0, 99);
    if (pick < 36) begin
      c = make_strip($urandom_range(0, 3) == 0);
    end else if (pick < 54) begin
      c = noise_cmd(ACT_FETCH);
    end else if (pick < 76) begin
      c = noise_cmd((pick < 68) ? ACT_COMPLETE : ACT_ABORT);
      case ($urandom_range(0, 9))
        0: ;
        1: c.sequence_number = sb.seq_front + 32'd1;
        2: c.sequence_number = sb.seq_front;
        default: c.sequence_number = sb.seq_flight;
      endcase
    end else if (pick < 83) begin
      c = noise_cmd(ACT_SET_REV);
      case ($urandom_range(0, 9))
        0, 1: c.revision = sb.rev_now;
        2, 3, 4: ;
        default: c.revision = sb.rev_now + 32'd1;
      endcase
    end else if (pick < 93) begin
      c = noise_cmd(ACT_READ_CNT);
    end else if (pick < 96) begin
      c = noise_cmd(($urandom_range(0, 1)) ? ACT_SPARE_LO : ACT_SPARE_HI);
    end else begin
      c = noise_cmd(3'($urandom_range(0, 7)));
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One command transaction: optional idle gap, then hold start until busy is
  // seen low at an edge. Start stays high afterwards so a following command
  // can go out back to back.
  task automatic send_command(strip_cmd_t c, int idle_pct);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_action          <= c.action;
    in_left_x          <= c.left_x;
    in_top_y           <= c.top_y;
    in_right_x         <= c.right_x;
    in_bottom_y        <= c.bottom_y;
    in_row_stride      <= c.row_stride;
    in_revision_in     <= c.revision;
    in_pixel_base      <= c.pixel_base;
    in_pixel_count     <= c.pixel_count;
    in_sequence_number <= c.sequence_number;
    in_counter_select  <= c.counter_select;
    start              <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(c);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // panel registers change only with the block idle
  task automatic write_panel(int seg);
    logic [14:0] w, h;
    case (seg)
      0: begin w = 15'd32767; h = 15'd32767; end
      1: begin w = 15'd2;     h = 15'd2;     end
      2: begin w = 15'd1;     h = 15'd32767; end   // nothing can fit
      4: begin w = 15'd32767; h = 15'd2;     end
      default: begin
        w = 15'($urandom_range(2, 600));
        h = 15'($urandom_range(1, 32767));
      end
    endcase
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PANEL_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_PANEL_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_panel(w, h);
  endtask

  // Directed run on the reset panel (256 x 256) and revision zero.
  task automatic run_directed();
    strip_cmd_t c;
    c = noise_cmd(ACT_READ_CNT);
    c.counter_select = SEL_QUEUED;
    send_command(c, 0);
    send_command(noise_cmd(ACT_FETCH), 0);                     // empty queue
    c = noise_cmd(ACT_COMPLETE);
    c.sequence_number = '0;
    send_command(c, 0);                                        // nothing in flight
    send_command(strip_at(0, 0, 256, 256, 256, 0, 65536), 0);  // whole panel, exact count
    send_command(strip_at(0, 0, 256, 256, 256, 0, 65535), 0);  // one pixel short
    send_command(strip_at(0, 0, 2, 2, 2, 1, 4), 0);            // stale revision
    send_command(strip_at(-2, 0, 2, 2, 4, 0, 100), 0);         // negative origin
    send_command(strip_at(1, 0, 3, 2, 2, 0, 100), 0);          // odd alignment
    send_command(strip_at(0, 0, 4, 2, 3, 0, 100), 0);          // stride under width
    send_command(strip_at(4, 0, 4, 2, 4, 0, 100), 0);          // zero width
    send_command(strip_at(0, 0, 2, 258, 2, 0, 1000), 0);       // below the panel
    send_command(strip_at(-32768, -32768, 32767, 32767, 32767, 0, 0), 0);
    c = strip_at(0, 0, 2, 2, 32767, 0, 32'hFFFF_FFFF);
    c.pixel_base = 32'hFFFF_FFFF;
    send_command(c, 0);                                        // queued behind the first
    send_command(noise_cmd(ACT_FETCH), 0);
    send_command(noise_cmd(ACT_FETCH), 0);                     // already in flight
    c = noise_cmd(ACT_COMPLETE);
    c.sequence_number = sb.seq_flight + 32'd1;
    send_command(c, 0);                                        // wrong sequence
    c = noise_cmd(ACT_SET_REV);
    c.revision = 32'd5;
    send_command(c, 0);                                        // head in flight, kept
    c = noise_cmd(ACT_COMPLETE);
    c.sequence_number = sb.seq_flight;
    send_command(c, 0);                                        // retire, then drop stale
    c = noise_cmd(ACT_READ_CNT);
    c.counter_select = 3'(STAT_STALE);
    send_command(c, 0);
    send_command(strip_at(0, 0, 2, 2, 2, 5, 4), 0);
    send_command(noise_cmd(ACT_FETCH), 0);
    c = noise_cmd(ACT_ABORT);
    c.sequence_number = sb.seq_flight;
    send_command(c, 0);
    send_command(noise_cmd(ACT_SPARE_LO), 0);
    send_command(noise_cmd(ACT_SPARE_HI), 0);
    c = noise_cmd(ACT_READ_CNT);
    c.counter_select = SEL_SPARE_LO;
    send_command(c, 0);
    c.counter_select = SEL_SPARE_HI;
    send_command(c, 0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int seg, n, idle;
    sb = new();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_PANEL_WIDTH;
    cfg_data           <= '0;
    start              <= 1'b0;
    in_action          <= ACT_SCHEDULE;
    in_left_x          <= '0;
    in_top_y           <= '0;
    in_right_x         <= '0;
    in_bottom_y        <= '0;
    in_row_stride      <= '0;
    in_revision_in     <= '0;
    in_pixel_base      <= '0;
    in_pixel_count     <= '0;
    in_sequence_number <= '0;
    in_counter_select  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // two panel settings per idle rate: light, heavy, then none
    for (seg = 0; seg < SEGMENTS; seg++) begin
      idle = (seg < 2) ? IDLE_LIGHT : (seg < 4) ? IDLE_HEAVY : 0;
      write_panel(seg);
      for (n = 0; n < RANDOM_ITEMS / SEGMENTS; n++)
        send_command(random_command(), idle);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
